// ===== rtl/pbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbc_pkg: shared types and constants for the padded bounding cube reducer
// Word layouts of both channels, the bounds word between the accumulator and
// the cube pipeline, and the Q16.16 constants of the cube padding.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned AXES    = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Largest and smallest Q16.16 values, used to seed the running extremes
  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  // 0.05 and 0.02 in Q16.16, 0.015 in Q0.32, rounding offset of the Q9.48 product
  localparam logic [30:0] MIN_HALF   = 31'd3277;
  localparam logic [25:0] MIN_PAD    = 26'd1311;
  localparam logic [25:0] PAD_FACTOR = 26'd64424509;
  localparam logic [57:0] PAD_ROUND  = 58'h0_0000_8000_0000;

  // Input word: one box
  typedef struct packed {
    logic                      entity_present;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
    logic                      last_entry;
  } in_item_t;

  // Result word: one cube
  typedef struct packed {
    logic                      bounds_valid;
    logic signed [COORD_W-1:0] cube_min_x;
    logic signed [COORD_W-1:0] cube_min_y;
    logic signed [COORD_W-1:0] cube_min_z;
    logic signed [COORD_W-1:0] cube_max_x;
    logic signed [COORD_W-1:0] cube_max_y;
    logic signed [COORD_W-1:0] cube_max_z;
  } out_item_t;

  // Final union of one set, handed from the accumulator to the cube pipeline
  typedef struct packed {
    logic                   strobe;
    logic                   seen;
    coord_t [AXES-1:0]      lo;
    coord_t [AXES-1:0]      hi;
  } bounds_t;

  // Control bits that travel alongside the cube pipeline
  typedef struct packed {
    logic strobe;
    logic seen;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/pbc_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbc_accum: box register and running union
// Registers each accepted box, folds valid boxes into the running minimum and
// maximum per axis, and on the last box of a set hands the union onward and
// reseeds the running state.
// ----------------------------------------------------------------------------
module pbc_accum (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_take,
  input  pbc_pkg::in_item_t  in_item,
  output pbc_pkg::bounds_t   bnd
);
  import pbc_pkg::*;

  logic                   take_r;
  in_item_t               item_r;
  coord_t [AXES-1:0]      lo_r;
  coord_t [AXES-1:0]      hi_r;
  logic                   seen_r;
  bounds_t                bnd_r;

  coord_t [AXES-1:0]      box_lo;
  coord_t [AXES-1:0]      box_hi;
  coord_t [AXES-1:0]      lo_mrg;
  coord_t [AXES-1:0]      hi_mrg;
  logic                   box_ok;
  logic                   seen_mrg;

  // Unpack the registered box per axis
  always_comb begin
    box_lo[0] = item_r.box_min_x;
    box_lo[1] = item_r.box_min_y;
    box_lo[2] = item_r.box_min_z;
    box_hi[0] = item_r.box_max_x;
    box_hi[1] = item_r.box_max_y;
    box_hi[2] = item_r.box_max_z;
  end

  // Qualify the box and merge it with the running extremes
  always_comb begin
    box_ok = item_r.entity_present;
    for (int i = 0; i < AXES; i++) begin
      if ($signed(box_lo[i]) > $signed(box_hi[i])) begin
        box_ok = 1'b0;
      end
    end
    for (int i = 0; i < AXES; i++) begin
      lo_mrg[i] = (box_ok && ($signed(box_lo[i]) < $signed(lo_r[i]))) ? box_lo[i] : lo_r[i];
      hi_mrg[i] = (box_ok && ($signed(box_hi[i]) > $signed(hi_r[i]))) ? box_hi[i] : hi_r[i];
    end
    seen_mrg = seen_r | box_ok;
  end

  // Capture boxes, advance the union, hand off and reseed on the last box
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      take_r     <= 1'b0;
      seen_r     <= 1'b0;
      bnd_r.strobe <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        lo_r[i] <= COORD_MAX;
        hi_r[i] <= COORD_MIN;
      end
    end else begin
      take_r <= in_take;
      if (in_take) begin
        item_r <= in_item;
      end
      bnd_r.strobe <= take_r && item_r.last_entry;
      bnd_r.seen   <= seen_mrg;
      bnd_r.lo     <= lo_mrg;
      bnd_r.hi     <= hi_mrg;
      if (take_r) begin
        if (item_r.last_entry) begin
          seen_r <= 1'b0;
          for (int i = 0; i < AXES; i++) begin
            lo_r[i] <= COORD_MAX;
            hi_r[i] <= COORD_MIN;
          end
        end else begin
          seen_r <= seen_mrg;
          lo_r   <= lo_mrg;
          hi_r   <= hi_mrg;
        end
      end
    end
  end

  assign bnd = bnd_r;

endmodule

`default_nettype wire

// ===== rtl/pbc_cube.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbc_cube: padded cube pipeline
// Five register stages: extents and centers, clamped half size, padding
// product, padded half size, then saturated cube corners in the result word.
// ----------------------------------------------------------------------------
module pbc_cube (
  input  wire                clk,
  input  wire                rst_n,
  input  pbc_pkg::bounds_t   bnd,
  output logic               out_strobe,
  output pbc_pkg::out_item_t out_item
);
  import pbc_pkg::*;

  // Clamp a 34-bit signed value into the Q16.16 range
  function automatic coord_t sat32(input logic signed [33:0] v);
    coord_t r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = COORD_MAX;
    end else if (v < -34'sh0_8000_0000) begin
      r = COORD_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  pipe_ctl_t              s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r;
  logic [AXES-1:0][31:0]  s1_ext_r;
  coord_t [AXES-1:0]      s1_ctr_r, s2_ctr_r, s3_ctr_r, s4_ctr_r;
  logic [30:0]            s2_half_r, s3_half_r;
  logic [56:0]            s3_prod_r;
  logic [31:0]            s4_h_r;
  logic                   out_strobe_r;
  out_item_t              out_item_r;

  logic [AXES-1:0][31:0]  s1_ext_nxt;
  coord_t [AXES-1:0]      s1_ctr_nxt;
  logic [31:0]            largest;
  logic [30:0]            s2_half_nxt;
  logic [56:0]            s3_prod_nxt;
  logic [57:0]            prod_rnd;
  logic [25:0]            rel;
  logic [25:0]            pad;
  logic [31:0]            s4_h_nxt;
  coord_t [AXES-1:0]      cmin;
  coord_t [AXES-1:0]      cmax;
  out_item_t              out_item_nxt;

  // Extent and center per axis; the center lies within the union, so 32 bits hold it
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      s1_ext_nxt[i] = bnd.hi[i] - bnd.lo[i];
      s1_ctr_nxt[i] = bnd.lo[i] + {1'b0, s1_ext_nxt[i][31:1]};
    end
  end

  // Largest extent, halved and raised to the minimum half size
  always_comb begin
    largest = s1_ext_r[0];
    if (s1_ext_r[1] > largest) begin
      largest = s1_ext_r[1];
    end
    if (s1_ext_r[2] > largest) begin
      largest = s1_ext_r[2];
    end
    s2_half_nxt = (largest[31:1] < MIN_HALF) ? MIN_HALF : largest[31:1];
  end

  // Relative padding: half size times the Q0.32 factor, in Q9.48
  assign s3_prod_nxt = {26'd0, s2_half_r} * {31'd0, PAD_FACTOR};

  // Round the padding, take the larger pad, form the padded half size
  always_comb begin
    prod_rnd = {1'b0, s3_prod_r} + PAD_ROUND;
    rel      = prod_rnd[57:32];
    pad      = (rel > MIN_PAD) ? rel : MIN_PAD;
    s4_h_nxt = {1'b0, s3_half_r} + {6'd0, pad};
  end

  // Cube corners, saturated; zeros when the set had no valid box
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      cmin[i] = sat32({{2{s4_ctr_r[i][31]}}, s4_ctr_r[i]} - {2'b00, s4_h_r});
      cmax[i] = sat32({{2{s4_ctr_r[i][31]}}, s4_ctr_r[i]} + {2'b00, s4_h_r});
    end
    out_item_nxt = '0;
    if (s4_ctl_r.seen) begin
      out_item_nxt.bounds_valid = 1'b1;
      out_item_nxt.cube_min_x   = cmin[0];
      out_item_nxt.cube_min_y   = cmin[1];
      out_item_nxt.cube_min_z   = cmin[2];
      out_item_nxt.cube_max_x   = cmax[0];
      out_item_nxt.cube_max_y   = cmax[1];
      out_item_nxt.cube_max_z   = cmax[2];
    end
  end

  // Advance the pipeline every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r     <= '0;
      s2_ctl_r     <= '0;
      s3_ctl_r     <= '0;
      s4_ctl_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_ctl_r     <= '{strobe: bnd.strobe, seen: bnd.seen};
      s2_ctl_r     <= s1_ctl_r;
      s3_ctl_r     <= s2_ctl_r;
      s4_ctl_r     <= s3_ctl_r;
      out_strobe_r <= s4_ctl_r.strobe;
    end
  end

  // Payload stages hold no reset
  always_ff @(posedge clk) begin
    s1_ext_r   <= s1_ext_nxt;
    s1_ctr_r   <= s1_ctr_nxt;
    s2_half_r  <= s2_half_nxt;
    s2_ctr_r   <= s1_ctr_r;
    s3_prod_r  <= s3_prod_nxt;
    s3_half_r  <= s2_half_r;
    s3_ctr_r   <= s2_ctr_r;
    s4_h_r     <= s4_h_nxt;
    s4_ctr_r   <= s3_ctr_r;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/padded_bounding_cube_reduce_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// padded_bounding_cube_reduce_core: padded bounding cube of a box stream
//
//   channel  ports                    word        handshake
//   input    start, busy, in_item     in_item_t   taken when start && !busy
//   result   out_strobe, out_item     out_item_t  one-cycle strobe, no stall
//
// One box is taken every cycle; busy is high only while reset is held.
// The box that closes a set passes the box register, the union register and
// the cube pipeline stages before its cube appears.
// Sets may follow each other with no gap; the union reseeds on its own.
// Reset is synchronous and clears the union and all strobes.
// ----------------------------------------------------------------------------
module padded_bounding_cube_reduce_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  pbc_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output pbc_pkg::out_item_t out_item
);
  import pbc_pkg::*;

  bounds_t bnd;
  logic    in_take;

  // Accept a word whenever the block is out of reset
  assign busy    = ~rst_n;
  assign in_take = start & ~busy;

  pbc_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_item (in_item),
    .bnd     (bnd)
  );

  pbc_cube u_cube (
    .clk        (clk),
    .rst_n      (rst_n),
    .bnd        (bnd),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

// ===== rtl/pbc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbc_checker: port-level checks for the padded bounding cube reducer
// Watches both channels and checks result timing and cube shape.
// ----------------------------------------------------------------------------
module pbc_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                start,
  input wire                busy,
  input pbc_pkg::in_item_t  in_item,
  input wire                out_strobe,
  input pbc_pkg::out_item_t out_item
);
  import pbc_pkg::*;

  // An empty set gives an all-zero cube
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.bounds_valid) |->
      (out_item.cube_min_x == '0 && out_item.cube_min_y == '0 &&
       out_item.cube_min_z == '0 && out_item.cube_max_x == '0 &&
       out_item.cube_max_y == '0 && out_item.cube_max_z == '0))
    else $error("empty set gave a nonzero cube");

  // A valid cube is never inverted on any axis
  a_cube_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.bounds_valid) |->
      ($signed(out_item.cube_min_x) < $signed(out_item.cube_max_x) &&
       $signed(out_item.cube_min_y) < $signed(out_item.cube_max_y) &&
       $signed(out_item.cube_min_z) < $signed(out_item.cube_max_z)))
    else $error("cube minimum not below maximum");

  // Every result traces back to an accepted last word
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && in_item.last_entry, 7))
    else $error("result without a closing word");

  // Every accepted word yields a result exactly when it closes a set
  a_one_per_set: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) &&
     $past(rst_n, 5) && $past(rst_n, 6) && $past(start && !busy, 7)) |->
      (out_strobe == $past(in_item.last_entry, 7)))
    else $error("result missing or extra for an accepted word");

endmodule

bind padded_bounding_cube_reduce_core pbc_checker u_pbc_checker (.*);

`default_nettype wire
